// ===== design/segment_allocator_split_coalesce_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SEGMENT_ALLOCATOR_SPLIT_COALESCE_ASSERT_SVH
`define SEGMENT_ALLOCATOR_SPLIT_COALESCE_ASSERT_SVH

// Assert that a condition implies a consequence on the same edge.
`define SASC_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Assert that a condition implies a consequence on the next edge.
`define SASC_ASSERT_NXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sasc_pkg.sv =====
package sasc_pkg;

    localparam int unsigned SIZE_W   = 17;
    localparam int unsigned OFF_W    = 16;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_W    = 17;

    localparam logic [SIZE_W-1:0] POOL_MAX   = 17'd65536;
    localparam logic [SIZE_W-1:0] POOL_RESET = 17'd1024;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_NOFIT  = 3'd1,
        ST_FULL   = 3'd2,
        ST_BADOFF = 3'd3,
        ST_ZERO   = 3'd4
    } status_t;

    localparam logic REG_TOTAL_SIZE = 1'b0;
    localparam logic REG_FIT_MODE   = 1'b1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN,
        S_DECIDE,
        S_SHUP_RD,
        S_SHUP_WR,
        S_SPLIT,
        S_MERGE_RD,
        S_MERGE,
        S_SHDN_RD,
        S_SHDN_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [OFF_W-1:0]  start;
        logic [SIZE_W-1:0] length;
        logic              used;
    } seg_t;

endpackage

// ===== design/segment_allocator_split_coalesce.sv =====
// Allocate scans the live segments, then shifts entries up by one on a split;
// free scans, then moves entries down on each of up to two drops.
// Throughput: one request at a time; busy stays high until done strobes.
// Reset: pool of 1024 units as one free segment, first fit, block idle.
// Results cannot be stalled: done is a one-cycle strobe.
module segment_allocator_split_coalesce #(
    parameter int unsigned MAX_SEGMENTS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          kind,
    input  logic [sasc_pkg::SIZE_W-1:0]   request_size,
    input  logic [sasc_pkg::OFF_W-1:0]    block_offset,
    output logic                          done,
    output logic [sasc_pkg::STATUS_W-1:0] status,
    output logic [sasc_pkg::OFF_W-1:0]    granted_offset,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [sasc_pkg::CFG_W-1:0]    cfg_data
);
    import sasc_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_SEGMENTS);
    localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

    // Segment table: one memory, read data registered.
    seg_t table_mem [MAX_SEGMENTS];
    seg_t rd_data;

    logic             we;
    logic [IDX_W-1:0] waddr;
    seg_t             wdata;
    logic [IDX_W-1:0] raddr;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            table_mem[waddr] <= wdata;
        end
        rd_data <= table_mem[raddr];
    end

    // Control and working registers.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              fit_reg, fit_next;
    logic [SIZE_W-1:0] pool_reg, pool_next;
    logic              init_reg, init_next;   // entry 0 still holds reset value
    logic [CNT_W-1:0]  k_reg, k_next;         // scan / shift pointer
    logic [IDX_W-1:0]  pick_reg, pick_next;
    logic              found_reg, found_next;
    seg_t              pseg_reg, pseg_next;   // picked / working segment
    seg_t              aux_reg, aux_next;     // neighbor segment
    logic              kind_reg, kind_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [OFF_W-1:0]  gnt_reg, gnt_next;
    logic              mstep_reg, mstep_next; // 0 successor merge, 1 predecessor

    // Entry 0 reads as its reset value until first written after init.
    seg_t rd_seg;
    logic [IDX_W-1:0] rd_addr_reg;
    always_ff @(posedge clk)
    begin
        rd_addr_reg <= raddr;
    end
    always_comb
    begin
        if (init_reg && rd_addr_reg == '0)
        begin
            rd_seg.start  = '0;
            rd_seg.length = pool_reg;
            rd_seg.used   = 1'b0;
        end
        else
        begin
            rd_seg = rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CNT_W'(1);
            fit_reg   <= 1'b0;
            pool_reg  <= POOL_RESET;
            init_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            fit_reg   <= fit_next;
            pool_reg  <= pool_next;
            init_reg  <= init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        pick_reg  <= pick_next;
        found_reg <= found_next;
        pseg_reg  <= pseg_next;
        aux_reg   <= aux_next;
        kind_reg  <= kind_next;
        size_reg  <= size_next;
        off_reg   <= off_next;
        st_reg    <= st_next;
        gnt_reg   <= gnt_next;
        mstep_reg <= mstep_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        fit_next   = fit_reg;
        pool_next  = pool_reg;
        init_next  = init_reg;
        k_next     = k_reg;
        pick_next  = pick_reg;
        found_next = found_reg;
        pseg_next  = pseg_reg;
        aux_next   = aux_reg;
        kind_next  = kind_reg;
        size_next  = size_reg;
        off_next   = off_reg;
        st_next    = st_reg;
        gnt_next   = gnt_reg;
        mstep_next = mstep_reg;
        we         = 1'b0;
        waddr      = '0;
        wdata      = pseg_reg;
        raddr      = k_reg[IDX_W-1:0];
        done       = 1'b0;

        // The user must write config only while idle; the block does not enforce it.
        if (cfg_we)
        begin
            case (cfg_index)
                REG_TOTAL_SIZE:
                begin
                    pool_next  = (cfg_data > POOL_MAX) ? POOL_MAX : cfg_data;
                    count_next = CNT_W'(1);
                    init_next  = 1'b1;
                end
                REG_FIT_MODE: fit_next = cfg_data[0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next  = kind;
                    size_next  = request_size;
                    off_next   = block_offset;
                    k_next     = '0;
                    found_next = 1'b0;
                    gnt_next   = '0;
                    if (kind == KIND_ALLOC && request_size == '0)
                    begin
                        st_next    = ST_ZERO;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            // Issue read of entry k.
            S_SCAN_RD:
            begin
                raddr      = k_reg[IDX_W-1:0];
                state_next = S_SCAN;
            end
            // Examine entry k.
            S_SCAN:
            begin
                if (kind_reg == KIND_ALLOC)
                begin
                    if (!rd_seg.used && rd_seg.length >= size_reg &&
                        (!found_reg || (fit_reg && rd_seg.length < pseg_reg.length)))
                    begin
                        found_next = 1'b1;
                        pick_next  = k_reg[IDX_W-1:0];
                        pseg_next  = rd_seg;
                    end
                    if ((found_next && !fit_reg) || k_reg + CNT_W'(1) >= count_reg)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        raddr      = k_next[IDX_W-1:0];
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    if (rd_seg.used && rd_seg.start == off_reg)
                    begin
                        found_next = 1'b1;
                        pick_next  = k_reg[IDX_W-1:0];
                        pseg_next  = rd_seg;
                        state_next = S_DECIDE;
                    end
                    else if (k_reg + CNT_W'(1) >= count_reg)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        raddr      = k_next[IDX_W-1:0];
                        state_next = S_SCAN;
                    end
                end
            end
            S_DECIDE:
            begin
                if (kind_reg == KIND_ALLOC)
                begin
                    if (!found_reg)
                    begin
                        st_next    = ST_NOFIT;
                        state_next = S_DONE;
                    end
                    else if (pseg_reg.length == size_reg)
                    begin
                        we         = 1'b1;
                        waddr      = pick_reg;
                        wdata      = pseg_reg;
                        wdata.used = 1'b1;
                        if (pick_reg == '0) init_next = 1'b0;
                        st_next    = ST_OK;
                        gnt_next   = pseg_reg.start;
                        state_next = S_DONE;
                    end
                    else if (count_reg >= CNT_MAX)
                    begin
                        st_next    = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // Shift entries pick+1..count-1 up by one, from the top.
                        k_next     = count_reg;
                        state_next = S_SHUP_RD;
                    end
                end
                else
                begin
                    if (!found_reg)
                    begin
                        st_next    = ST_BADOFF;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        st_next       = ST_OK;
                        pseg_next.used = 1'b0;
                        mstep_next    = 1'b0;
                        state_next    = S_MERGE_RD;
                    end
                end
            end
            S_SHUP_RD:
            begin
                if (k_reg > CNT_W'(pick_reg) + CNT_W'(1))
                begin
                    raddr      = IDX_W'(k_reg - CNT_W'(1));
                    state_next = S_SHUP_WR;
                end
                else
                begin
                    state_next = S_SPLIT;
                end
            end
            S_SHUP_WR:
            begin
                we         = 1'b1;
                waddr      = k_reg[IDX_W-1:0];
                wdata      = rd_seg;
                k_next     = k_reg - CNT_W'(1);
                state_next = S_SHUP_RD;
            end
            // Write remainder, then the used head on the next pass.
            S_SPLIT:
            begin
                we           = 1'b1;
                waddr        = pick_reg + IDX_W'(1);
                wdata.start  = pseg_reg.start + size_reg[OFF_W-1:0];
                wdata.length = pseg_reg.length - size_reg;
                wdata.used   = 1'b0;
                pseg_next.length = size_reg;
                pseg_next.used   = 1'b1;
                count_next   = count_reg + CNT_W'(1);
                mstep_next   = 1'b1;
                st_next      = ST_OK;
                gnt_next     = pseg_reg.start;
                state_next   = S_MERGE;
                aux_next.used = 1'b1;     // no merge: just write head
            end
            // Read neighbor: successor, then predecessor.
            S_MERGE_RD:
            begin
                if (!mstep_reg)
                begin
                    if (CNT_W'(pick_reg) + CNT_W'(1) < count_reg)
                    begin
                        raddr      = pick_reg + IDX_W'(1);
                        state_next = S_MERGE;
                    end
                    else
                    begin
                        aux_next.used = 1'b1;
                        state_next    = S_MERGE;
                    end
                end
                else
                begin
                    if (pick_reg != '0)
                    begin
                        raddr      = pick_reg - IDX_W'(1);
                        state_next = S_MERGE;
                    end
                    else
                    begin
                        aux_next.used = 1'b1;
                        state_next    = S_MERGE;
                    end
                end
            end
            S_MERGE:
            begin : merge_blk
                seg_t nb;
                // A set used mark in aux means there is no neighbor on this side.
                nb = rd_seg;
                if (aux_reg.used)
                begin
                    nb.used = 1'b1;
                end
                if (nb.used)
                begin
                    // No merge on this side: write back working entry.
                    we    = 1'b1;
                    waddr = pick_reg;
                    wdata = pseg_reg;
                    if (pick_reg == '0) init_next = 1'b0;
                    aux_next.used = 1'b0;
                    if (!mstep_reg)
                    begin
                        mstep_next = 1'b1;
                        state_next = S_MERGE_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (!mstep_reg)
                begin
                    // Absorb successor, drop it.
                    pseg_next.length = pseg_reg.length + nb.length;
                    we     = 1'b1;
                    waddr  = pick_reg;
                    wdata  = pseg_reg;
                    wdata.length = pseg_reg.length + nb.length;
                    if (pick_reg == '0) init_next = 1'b0;
                    k_next     = CNT_W'(pick_reg) + CNT_W'(1);
                    mstep_next = 1'b1;
                    state_next = S_SHDN_RD;
                end
                else
                begin
                    // Predecessor absorbs this entry.
                    we           = 1'b1;
                    waddr        = pick_reg - IDX_W'(1);
                    wdata        = nb;
                    wdata.length = nb.length + pseg_reg.length;
                    k_next       = CNT_W'(pick_reg);
                    pick_next    = pick_reg - IDX_W'(1);
                    mstep_next   = 1'b0;
                    gnt_next     = '0;
                    state_next   = S_SHDN_RD;
                    st_next      = ST_OK;
                    found_next   = 1'b0; // marks final drop
                end
            end
            // Drop entry: move k+1 into k until the end.
            S_SHDN_RD:
            begin
                if (k_reg + CNT_W'(1) < count_reg)
                begin
                    raddr      = IDX_W'(k_reg + CNT_W'(1));
                    state_next = S_SHDN_WR;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (found_reg)
                    begin
                        // Successor dropped; now look at predecessor.
                        mstep_next = 1'b1;
                        state_next = S_MERGE_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SHDN_WR:
            begin
                we         = 1'b1;
                waddr      = k_reg[IDX_W-1:0];
                wdata      = rd_seg;
                k_next     = k_reg + CNT_W'(1);
                state_next = S_SHDN_RD;
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy           = (state_reg != S_IDLE);
    assign status         = st_reg;
    assign granted_offset = gnt_reg;

endmodule

// ===== design/sasc_checker.sv =====
module sasc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [sasc_pkg::STATUS_W-1:0] status,
    input logic [sasc_pkg::OFF_W-1:0]    granted_offset
);
    import sasc_pkg::*;

    `include "segment_allocator_split_coalesce_assert.svh"

    `SASC_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted word without busy")
    `SASC_ASSERT_IMP(a_done_busy, clk, rst_n, done, busy, "done strobe while idle")
    `SASC_ASSERT_NXT(a_done_ends, clk, rst_n, done, !busy && !done, "busy held after done")
    `SASC_ASSERT_IMP(a_status_range, clk, rst_n, done, status <= ST_ZERO, "status out of range")
    `SASC_ASSERT_IMP(a_gnt_zero, clk, rst_n, done && status != ST_OK, granted_offset == '0, "offset on error")

endmodule

bind segment_allocator_split_coalesce sasc_checker u_sasc_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .status(status), .granted_offset(granted_offset)
);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import sasc_pkg::*;

    localparam int unsigned NSEG = 64;
    // Cycles with no accepted word and no done strobe before giving up.
    localparam int unsigned STALL_LIMIT = 5000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                kind;
    logic [SIZE_W-1:0]   request_size;
    logic [OFF_W-1:0]    block_offset;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    granted_offset;
    logic                cfg_we;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    segment_allocator_split_coalesce #(.MAX_SEGMENTS(NSEG)) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .request_size   (request_size),
        .block_offset   (block_offset),
        .done           (done),
        .status         (status),
        .granted_offset (granted_offset),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Shadow copy of the segment table and the registers.
    logic [OFF_W-1:0]  tbl_start [NSEG];
    logic [SIZE_W-1:0] tbl_len [NSEG];
    bit                tbl_used [NSEG];
    int unsigned       tbl_count;
    logic [SIZE_W-1:0] pool_size;
    bit                best_fit;

    // Outcomes still owed by the block, oldest first.
    status_t           owed_status [$];
    logic [OFF_W-1:0]  owed_offset [$];
    // Offsets currently held by the stimulus, used to build legal frees.
    logic [OFF_W-1:0]  held [$];

    int unsigned       errors = 0;
    int unsigned       quiet_cycles = 0;
    bit                allow_gaps;

    function automatic void table_reset();
        tbl_start[0] = '0;
        tbl_len[0]   = pool_size;
        tbl_used[0]  = 1'b0;
        tbl_count    = 1;
    endfunction

    function automatic void drop_segment(input int unsigned idx);
        for (int unsigned k = idx; k + 1 < tbl_count; k++)
        begin
            tbl_start[k] = tbl_start[k+1];
            tbl_len[k]   = tbl_len[k+1];
            tbl_used[k]  = tbl_used[k+1];
        end
        tbl_count--;
    endfunction

    // Compute the outcome of one request and advance the shadow table.
    function automatic void model_request(input logic k, input logic [SIZE_W-1:0] sz,
                                          input logic [OFF_W-1:0] off,
                                          output status_t st, output logic [OFF_W-1:0] g);
        int unsigned pick;
        int unsigned idx;
        bit          found;
        pick  = 0;
        idx   = 0;
        found = 1'b0;
        g     = '0;
        if (k == KIND_ALLOC)
        begin
            if (sz == 0)
            begin
                st = ST_ZERO;
                return;
            end
            for (int unsigned i = 0; i < tbl_count; i++)
            begin
                if (tbl_used[i] || tbl_len[i] < sz)
                    continue;
                if (!found || (best_fit && tbl_len[i] < tbl_len[pick]))
                begin
                    pick  = i;
                    found = 1'b1;
                    if (!best_fit)
                        break;
                end
            end
            if (!found)
            begin
                st = ST_NOFIT;
                return;
            end
            if (tbl_len[pick] > sz)
            begin
                if (tbl_count >= NSEG)
                begin
                    st = ST_FULL;
                    return;
                end
                // Open a hole after the pick for the remainder.
                for (int unsigned i = tbl_count; i > pick + 1; i--)
                begin
                    tbl_start[i] = tbl_start[i-1];
                    tbl_len[i]   = tbl_len[i-1];
                    tbl_used[i]  = tbl_used[i-1];
                end
                tbl_start[pick+1] = tbl_start[pick] + sz[OFF_W-1:0];
                tbl_len[pick+1]   = tbl_len[pick] - sz;
                tbl_used[pick+1]  = 1'b0;
                tbl_count++;
                tbl_len[pick] = sz;
            end
            tbl_used[pick] = 1'b1;
            g  = tbl_start[pick];
            st = ST_OK;
        end
        else
        begin
            for (int unsigned i = 0; i < tbl_count; i++)
            begin
                if (tbl_used[i] && tbl_start[i] == off)
                begin
                    idx   = i;
                    found = 1'b1;
                    break;
                end
            end
            if (!found)
            begin
                st = ST_BADOFF;
                return;
            end
            tbl_used[idx] = 1'b0;
            // Merge with a free successor, then with a free predecessor.
            if (idx + 1 < tbl_count && !tbl_used[idx+1])
            begin
                tbl_len[idx] += tbl_len[idx+1];
                drop_segment(idx + 1);
            end
            if (idx > 0 && !tbl_used[idx-1])
            begin
                tbl_len[idx-1] += tbl_len[idx];
                drop_segment(idx);
            end
            st = ST_OK;
        end
    endfunction

    // Send one request word; return at the edge that accepts it.
    task automatic send_request(input logic k, input logic [SIZE_W-1:0] sz,
                                input logic [OFF_W-1:0] off);
        status_t          st;
        logic [OFF_W-1:0] g;
        start        <= 1'b1;
        kind         <= k;
        request_size <= sz;
        block_offset <= off;
        do
            @(posedge clk);
        while (busy);
        model_request(k, sz, off, st, g);
        owed_status.push_back(st);
        owed_offset.push_back(g);
        if (st == ST_OK)
        begin
            if (k == KIND_ALLOC)
                held.push_back(g);
            else
                for (int i = 0; i < held.size(); i++)
                begin
                    if (held[i] == off)
                    begin
                        held.delete(i);
                        break;
                    end
                end
        end
    endtask

    // Drop start and idle; n sets how long.
    task automatic idle_cycles(input int unsigned n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic maybe_gap();
        if (allow_gaps && $urandom_range(0, 2) == 0)
            idle_cycles($urandom_range(1, 4));
    endtask

    // Hold until every owed word has come back and the block is idle.
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (owed_status.size() != 0 || busy);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_TOTAL_SIZE)
        begin
            pool_size = (val > POOL_MAX) ? POOL_MAX : val;
            table_reset();
            held.delete();
        end
        else
            best_fit = val[0];
    endtask

    // Compare each done word against the oldest owed outcome.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (owed_status.size() == 0)
            begin
                $error("done word with nothing owed: status %0d offset %0d",
                       status, granted_offset);
                errors++;
            end
            else
            begin
                if (status !== owed_status[0])
                begin
                    $error("status: expected %0d actual %0d", owed_status[0], status);
                    errors++;
                end
                if (granted_offset !== owed_offset[0])
                begin
                    $error("granted_offset: expected %0d actual %0d",
                           owed_offset[0], granted_offset);
                    errors++;
                end
                void'(owed_status.pop_front());
                void'(owed_offset.pop_front());
            end
        end
    end

    // Watchdog: count cycles where nothing moves in or out.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL segment_allocator_split_coalesce");
            $finish;
        end
    end

    // Reset pool: zero size, too large, exact fit, double free, extremes.
    task automatic test_reset_pool();
        send_request(KIND_ALLOC, 17'd0, 16'd0);
        send_request(KIND_ALLOC, 17'd1025, 16'd0);
        send_request(KIND_ALLOC, POOL_MAX, 16'hFFFF);
        send_request(KIND_ALLOC, 17'd1024, 16'd0);
        send_request(KIND_FREE, 17'h1FFFF, 16'd0);
        send_request(KIND_FREE, 17'd0, 16'd0);
        send_request(KIND_ALLOC, 17'd1, 16'd0);
        send_request(KIND_FREE, 17'd0, 16'hFFFF);
        send_request(KIND_FREE, 17'd0, 16'd0);
    endtask

    // Pool size extremes, saturation and best fit against first fit.
    task automatic test_pool_config();
        write_reg(REG_TOTAL_SIZE, 17'd0);
        send_request(KIND_ALLOC, 17'd1, 16'd0);
        write_reg(REG_TOTAL_SIZE, 17'h1FFFF);
        send_request(KIND_ALLOC, POOL_MAX, 16'd0);
        send_request(KIND_FREE, 17'd0, 16'd0);
        write_reg(REG_TOTAL_SIZE, 17'd100);
        // Holes of 30 at 0 and 10 at 40; best fit must take the later one.
        send_request(KIND_ALLOC, 17'd30, 16'd0);
        send_request(KIND_ALLOC, 17'd10, 16'd0);
        send_request(KIND_ALLOC, 17'd10, 16'd0);
        send_request(KIND_ALLOC, 17'd10, 16'd0);
        send_request(KIND_FREE, 17'd0, 16'd0);
        send_request(KIND_FREE, 17'd0, 16'd40);
        write_reg(REG_FIT_MODE, 17'd1);
        send_request(KIND_ALLOC, 17'd8, 16'd0);
        write_reg(REG_FIT_MODE, 17'd0);
        send_request(KIND_ALLOC, 17'd8, 16'd0);
    endtask

    // Fill the table, then exact fit on a full table and merges.
    task automatic test_table_full();
        write_reg(REG_TOTAL_SIZE, 17'd100);
        for (int i = 0; i < NSEG - 1; i++)
            send_request(KIND_ALLOC, 17'd1, 16'd0);
        send_request(KIND_ALLOC, 17'd1, 16'd0);
        send_request(KIND_ALLOC, 17'd37, 16'd0);
        send_request(KIND_FREE, 17'd0, 16'd5);
        send_request(KIND_FREE, 17'd0, 16'd7);
        send_request(KIND_FREE, 17'd0, 16'd6);
        send_request(KIND_ALLOC, 17'd3, 16'd0);
    endtask

    task automatic random_word();
        logic [SIZE_W-1:0] sz;
        logic [OFF_W-1:0]  off;
        int unsigned       r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            sz = SIZE_W'($urandom_range(1, pool_size / 6 + 1));
            if ($urandom_range(0, 19) == 0)
                sz = '0;
            else if ($urandom_range(0, 19) == 0)
                sz = SIZE_W'($urandom);
            send_request(KIND_ALLOC, sz, OFF_W'($urandom));
        end
        else if (r < 90 && held.size() != 0)
        begin
            off = held[$urandom_range(0, held.size() - 1)];
            send_request(KIND_FREE, SIZE_W'($urandom), off);
        end
        else
        begin
            off = OFF_W'($urandom);
            if (held.size() != 0 && $urandom_range(0, 1) == 0)
                off = held[0] + OFF_W'(1);
            send_request(KIND_FREE, SIZE_W'($urandom), off);
        end
    endtask

    // Random phases, each with its own pool size and fit mode.
    task automatic test_random_traffic();
        logic [CFG_W-1:0] sz;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: sz = CFG_W'($urandom_range(1, 64));
                1: sz = CFG_W'($urandom_range(65, 4096));
                2: sz = POOL_MAX;
                default: sz = CFG_W'($urandom);
            endcase
            write_reg(REG_TOTAL_SIZE, sz);
            write_reg(REG_FIT_MODE, CFG_W'($urandom));
            if (phase == 7)
                allow_gaps = 1'b0;
            for (int i = 0; i < 40; i++)
            begin
                random_word();
                maybe_gap();
            end
        end
    endtask

    initial
    begin
        allow_gaps   = 1'b1;
        pool_size    = POOL_RESET;
        best_fit     = 1'b0;
        table_reset();
        rst_n        = 1'b0;
        start        = 1'b0;
        kind         = KIND_ALLOC;
        request_size = '0;
        block_offset = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_TOTAL_SIZE;
        cfg_data     = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_pool();
        test_pool_config();
        test_table_full();
        test_random_traffic();

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("PASS segment_allocator_split_coalesce");
        else
            $display("FAIL segment_allocator_split_coalesce");
        $finish;
    end

endmodule
